@@ rtl/gasp_pkg.sv @@
`default_nettype none
package gasp_pkg;

    // Field widths of the input and output words
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int IDX_W  = 10;
    localparam int LEN_W  = 11;
    localparam int OP_W   = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // Operation codes carried on tuser
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_IDLE   = 2'd3;

    // Per-cell search status
    localparam logic [1:0] ST_UNSEEN = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    // Neighbor directions in try order; the opposite of d is ~d
    typedef enum logic [1:0] {
        DIR_EAST  = 2'd0,
        DIR_NORTH = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

endpackage
`default_nettype wire

@@ rtl/gasp_ram.sv @@
`default_nettype none
module gasp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/gasp_nbr.sv @@
`default_nettype none
module gasp_nbr #(
    parameter int GRID_ROWS = 32,
    parameter int GRID_COLS = 128
) (
    input  wire logic [$clog2(GRID_ROWS)-1:0] row,
    input  wire logic [$clog2(GRID_COLS)-1:0] col,
    input  wire gasp_pkg::dir_t               dir,
    input  wire logic [$clog2(GRID_ROWS)-1:0] goal_row,
    input  wire logic [$clog2(GRID_COLS)-1:0] goal_col,
    input  wire logic [$clog2(GRID_ROWS*GRID_COLS+1)-1:0] g,
    output logic      [$clog2(GRID_ROWS)-1:0] nb_row,
    output logic      [$clog2(GRID_COLS)-1:0] nb_col,
    output logic                              in_grid,
    output logic [$clog2(GRID_ROWS*GRID_COLS+GRID_ROWS+GRID_COLS+1)-1:0] f
);
    import gasp_pkg::*;

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int FW = $clog2(GRID_ROWS*GRID_COLS+GRID_ROWS+GRID_COLS+1);

    logic [RW-1:0] dr;
    logic [CW-1:0] dc;

    // Step one cell and check the grid edge
    always_comb
    begin
        nb_row  = row;
        nb_col  = col;
        in_grid = 1'b1;
        case (dir)
            DIR_EAST:
            begin
                in_grid = (col != CW'(GRID_COLS-1));
                nb_col  = col + CW'(1);
            end
            DIR_NORTH:
            begin
                in_grid = (row != '0);
                nb_row  = row - RW'(1);
            end
            DIR_SOUTH:
            begin
                in_grid = (row != RW'(GRID_ROWS-1));
                nb_row  = row + RW'(1);
            end
            default:
            begin
                in_grid = (col != '0);
                nb_col  = col - CW'(1);
            end
        endcase
    end

    // Cost plus Manhattan distance to the goal
    always_comb
    begin
        dr = (nb_row > goal_row) ? nb_row - goal_row : goal_row - nb_row;
        dc = (nb_col > goal_col) ? nb_col - goal_col : goal_col - nb_col;
        f  = FW'(g) + FW'(dr) + FW'(dc);
    end

endmodule
`default_nettype wire

@@ rtl/grid_astar_path_search.sv @@
`default_nettype none
// A* path search over a GRID_ROWS x GRID_COLS map of free and blocked cells, 4-connected,
// unit step cost, Manhattan heuristic. tuser selects the operation: map write, search,
// or path read; each transfer in gives one transfer out with found, overflow and the path
// length of the last search. A search first clears the status memory, then expands cells
// one at a time through a single neighbor/cost unit: each expanded cell is popped and its
// cost read, then each neighbor is stepped to and, if on the grid, checked and pushed if
// free and unseen; when the current f bucket runs dry the next is taken, and at the goal
// the path is walked back cell by cell. The open list is two FIFO memories, the current f
// and f+2. After reset the map is cleared before the first transfer is taken. The block
// takes one item at a time.
module grid_astar_path_search #(
    parameter int GRID_ROWS  = 32,
    parameter int GRID_COLS  = 128,
    parameter int PATH_DEPTH = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // row[4:0], col[11:5], blocked[12], goal_row[17:13], goal_col[24:18],
    // path_index[34:25], zero [39:35]
    input  wire logic [gasp_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [gasp_pkg::OP_W-1:0] s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // found[0], overflow[1], path_length[12:2], path_row[17:13], path_col[24:18],
    // zero [31:25]
    output logic      [gasp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import gasp_pkg::*;

    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);
    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int QW    = $clog2(CELLS + 1);
    localparam int GW    = $clog2(CELLS + 1);
    localparam int FW    = $clog2(CELLS + GRID_ROWS + GRID_COLS + 1);
    localparam int PAW   = $clog2(PATH_DEPTH);
    localparam int PCW   = $clog2(PATH_DEPTH + 1);
    localparam int EW    = RW + CW;
    localparam int IW    = GW + 2;

    typedef enum logic [3:0] {
        S_CLRMAP, S_IDLE, S_RDPATH, S_CLRST, S_INIT, S_POP, S_POPW,
        S_COST, S_NBRD, S_NBCHK, S_WALK, S_WALKW
    } state_t;

    state_t state_reg;

    // Input fields
    logic [ROW_W-1:0] in_row, in_grow;
    logic [COL_W-1:0] in_col, in_gcol;
    logic             in_blocked;
    logic [IDX_W-1:0] in_idx;
    logic             accept;

    assign in_row     = s_axis_tdata[4:0];
    assign in_col     = s_axis_tdata[11:5];
    assign in_blocked = s_axis_tdata[12];
    assign in_grow    = s_axis_tdata[17:13];
    assign in_gcol    = s_axis_tdata[24:18];
    assign in_idx     = s_axis_tdata[34:25];

    logic             m_valid_reg;
    assign s_axis_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Search registers
    logic [RW-1:0]  sr_reg, gr_reg, cur_r_reg, nb_r_reg;
    logic [CW-1:0]  sc_reg, gc_reg, cur_c_reg, nb_c_reg;
    logic [GW-1:0]  g_reg;
    logic [FW-1:0]  fcur_reg, nb_f_reg;
    dir_t           dir_reg;
    logic           sel_reg;
    logic [QW-1:0]  head_reg [2];
    logic [QW-1:0]  tail_reg [2];
    logic [AW-1:0]  clr_cnt_reg;
    logic [PCW-1:0] path_cnt_reg;
    logic           found_reg, ovf_reg;
    logic [ROW_W-1:0] prow_reg;
    logic [COL_W-1:0] pcol_reg;

    // Memory ports
    logic           map_we, map_wd, map_rd;
    logic [AW-1:0]  map_wa, map_ra;
    logic           st_we;
    logic [1:0]     st_wd, st_rd;
    logic [AW-1:0]  st_wa, st_ra;
    logic           inf_we;
    logic [IW-1:0]  inf_wd, inf_rd;
    logic [AW-1:0]  inf_wa, inf_ra;
    logic [1:0]     q_we;
    logic [EW-1:0]  q_wd;
    logic [EW-1:0]  q_rd [2];
    logic [AW-1:0]  q_wa, q_ra;
    logic           p_we;
    logic [EW-1:0]  p_wd, p_rd;
    logic [PAW-1:0] p_wa, p_ra;

    // Shared neighbor and cost unit
    dir_t           nbr_dir;
    logic [RW-1:0]  nbr_row;
    logic [CW-1:0]  nbr_col;
    logic           nbr_ok;
    logic [FW-1:0]  nbr_f;

    logic [RW-1:0]  pop_r;
    logic [CW-1:0]  pop_c;
    logic           push_sel;
    logic           in_on_grid, in_goal_on_grid;
    logic [RW-1:0]  h_dr;
    logic [CW-1:0]  h_dc;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                 input logic [CW-1:0] c);
        return AW'(32'(r) * GRID_COLS + 32'(c));
    endfunction

    assign pop_r = q_rd[sel_reg][EW-1:CW];
    assign pop_c = q_rd[sel_reg][CW-1:0];
    assign push_sel = (nb_f_reg == fcur_reg) ? sel_reg : ~sel_reg;
    assign in_on_grid = (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);
    assign in_goal_on_grid = (32'(in_grow) < GRID_ROWS) && (32'(in_gcol) < GRID_COLS);
    assign nbr_dir = (state_reg == S_WALKW) ? dir_t'(~inf_rd[1:0]) : dir_reg;
    assign h_dr = (sr_reg > gr_reg) ? sr_reg - gr_reg : gr_reg - sr_reg;
    assign h_dc = (sc_reg > gc_reg) ? sc_reg - gc_reg : gc_reg - sc_reg;

    gasp_nbr #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_nbr (
        .row      (cur_r_reg),
        .col      (cur_c_reg),
        .dir      (nbr_dir),
        .goal_row (gr_reg),
        .goal_col (gc_reg),
        .g        (g_reg),
        .nb_row   (nbr_row),
        .nb_col   (nbr_col),
        .in_grid  (nbr_ok),
        .f        (nbr_f)
    );

    gasp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_map (
        .clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
        .raddr(map_ra), .rdata(map_rd)
    );
    gasp_ram #(.WIDTH(2), .DEPTH(CELLS)) u_status (
        .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
        .raddr(st_ra), .rdata(st_rd)
    );
    gasp_ram #(.WIDTH(IW), .DEPTH(CELLS)) u_info (
        .clk(clk), .we(inf_we), .waddr(inf_wa), .wdata(inf_wd),
        .raddr(inf_ra), .rdata(inf_rd)
    );
    gasp_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_queue0 (
        .clk(clk), .we(q_we[0]), .waddr(q_wa), .wdata(q_wd),
        .raddr(q_ra), .rdata(q_rd[0])
    );
    gasp_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_queue1 (
        .clk(clk), .we(q_we[1]), .waddr(q_wa), .wdata(q_wd),
        .raddr(q_ra), .rdata(q_rd[1])
    );
    gasp_ram #(.WIDTH(EW), .DEPTH(PATH_DEPTH)) u_path (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
        .raddr(p_ra), .rdata(p_rd)
    );

    // Drive memory ports from the sequencer state
    always_comb
    begin
        map_we = 1'b0;
        map_wa = clr_cnt_reg;
        map_wd = 1'b0;
        map_ra = cell_addr(nbr_row, nbr_col);
        st_we  = 1'b0;
        st_wa  = clr_cnt_reg;
        st_wd  = ST_UNSEEN;
        st_ra  = cell_addr(nbr_row, nbr_col);
        inf_we = 1'b0;
        inf_wa = cell_addr(nb_r_reg, nb_c_reg);
        inf_wd = {g_reg, dir_reg};
        inf_ra = cell_addr(cur_r_reg, cur_c_reg);
        q_we   = 2'b00;
        q_wa   = AW'(tail_reg[push_sel]);
        q_wd   = {nb_r_reg, nb_c_reg};
        q_ra   = AW'(head_reg[sel_reg]);
        p_we   = 1'b0;
        p_wa   = PAW'(path_cnt_reg);
        p_wd   = {cur_r_reg, cur_c_reg};
        p_ra   = PAW'(in_idx);
        case (state_reg)
            S_CLRMAP:
            begin
                map_we = 1'b1;
            end
            S_IDLE:
            begin
                map_we = accept && (s_axis_tuser == OP_WRITE) && in_on_grid;
                map_wa = cell_addr(RW'(in_row), CW'(in_col));
                map_wd = in_blocked;
            end
            S_CLRST:
            begin
                st_we = 1'b1;
            end
            S_INIT:
            begin
                st_we  = 1'b1;
                st_wa  = cell_addr(sr_reg, sc_reg);
                st_wd  = ST_OPEN;
                inf_we = 1'b1;
                inf_wa = cell_addr(sr_reg, sc_reg);
                inf_wd = '0;
                q_we   = 2'b01;
                q_wa   = '0;
                q_wd   = {sr_reg, sc_reg};
            end
            S_POPW:
            begin
                st_we  = 1'b1;
                st_wa  = cell_addr(pop_r, pop_c);
                st_wd  = ST_CLOSED;
                inf_ra = cell_addr(pop_r, pop_c);
            end
            S_NBCHK:
            begin
                if (!map_rd && st_rd == ST_UNSEEN)
                begin
                    st_we  = 1'b1;
                    st_wa  = cell_addr(nb_r_reg, nb_c_reg);
                    st_wd  = ST_OPEN;
                    inf_we = 1'b1;
                    q_we   = push_sel ? 2'b10 : 2'b01;
                end
            end
            S_WALK:
            begin
                p_we = (32'(path_cnt_reg) < PATH_DEPTH);
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLRMAP;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
            path_cnt_reg <= '0;
            found_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
            prow_reg     <= '0;
            pcol_reg     <= '0;
            sel_reg      <= 1'b0;
            dir_reg      <= DIR_EAST;
            head_reg[0]  <= '0;
            head_reg[1]  <= '0;
            tail_reg[0]  <= '0;
            tail_reg[1]  <= '0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLRMAP:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(CELLS-1))
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        prow_reg <= '0;
                        pcol_reg <= '0;
                        case (s_axis_tuser)
                            OP_SEARCH:
                            begin
                                sr_reg       <= RW'(in_row);
                                sc_reg       <= CW'(in_col);
                                gr_reg       <= RW'(in_grow);
                                gc_reg       <= CW'(in_gcol);
                                path_cnt_reg <= '0;
                                found_reg    <= 1'b0;
                                ovf_reg      <= 1'b0;
                                clr_cnt_reg  <= '0;
                                if (in_on_grid && in_goal_on_grid)
                                begin
                                    state_reg <= S_CLRST;
                                end
                                else
                                begin
                                    m_valid_reg <= 1'b1;
                                end
                            end
                            OP_READ:
                            begin
                                if ((32'(in_idx) < 32'(path_cnt_reg)) &&
                                    (32'(in_idx) < PATH_DEPTH))
                                begin
                                    state_reg <= S_RDPATH;
                                end
                                else
                                begin
                                    m_valid_reg <= 1'b1;
                                end
                            end
                            default:
                            begin
                                m_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RDPATH:
                begin
                    prow_reg    <= ROW_W'(p_rd[EW-1:CW]);
                    pcol_reg    <= COL_W'(p_rd[CW-1:0]);
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                S_CLRST:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(CELLS-1))
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    sel_reg     <= 1'b0;
                    head_reg[0] <= '0;
                    tail_reg[0] <= QW'(1);
                    head_reg[1] <= '0;
                    tail_reg[1] <= '0;
                    fcur_reg    <= FW'(h_dr) + FW'(h_dc);
                    state_reg   <= S_POP;
                end
                S_POP:
                begin
                    if (head_reg[sel_reg] == tail_reg[sel_reg])
                    begin
                        if (head_reg[~sel_reg] == tail_reg[~sel_reg])
                        begin
                            // open list ran empty
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_IDLE;
                        end
                        else
                        begin
                            // advance to the f+2 bucket, recycle the empty one
                            sel_reg            <= ~sel_reg;
                            fcur_reg           <= fcur_reg + FW'(2);
                            head_reg[sel_reg]  <= '0;
                            tail_reg[sel_reg]  <= '0;
                        end
                    end
                    else
                    begin
                        head_reg[sel_reg] <= head_reg[sel_reg] + QW'(1);
                        state_reg         <= S_POPW;
                    end
                end
                S_POPW:
                begin
                    cur_r_reg <= pop_r;
                    cur_c_reg <= pop_c;
                    if (pop_r == gr_reg && pop_c == gc_reg)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_WALK;
                    end
                    else
                    begin
                        state_reg <= S_COST;
                    end
                end
                S_COST:
                begin
                    g_reg     <= inf_rd[IW-1:2] + GW'(1);
                    dir_reg   <= DIR_EAST;
                    state_reg <= S_NBRD;
                end
                S_NBRD:
                begin
                    nb_r_reg <= nbr_row;
                    nb_c_reg <= nbr_col;
                    nb_f_reg <= nbr_f;
                    if (nbr_ok)
                    begin
                        state_reg <= S_NBCHK;
                    end
                    else if (dir_reg == DIR_WEST)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        dir_reg <= dir_t'(dir_reg + 2'd1);
                    end
                end
                S_NBCHK:
                begin
                    if (!map_rd && st_rd == ST_UNSEEN)
                    begin
                        tail_reg[push_sel] <= tail_reg[push_sel] + QW'(1);
                    end
                    if (dir_reg == DIR_WEST)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        dir_reg   <= dir_t'(dir_reg + 2'd1);
                        state_reg <= S_NBRD;
                    end
                end
                S_WALK:
                begin
                    if (32'(path_cnt_reg) < PATH_DEPTH)
                    begin
                        path_cnt_reg <= path_cnt_reg + PCW'(1);
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                    if (cur_r_reg == sr_reg && cur_c_reg == sc_reg)
                    begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_WALKW;
                    end
                end
                S_WALKW:
                begin
                    // step back toward the parent
                    cur_r_reg <= nbr_row;
                    cur_c_reg <= nbr_col;
                    state_reg <= S_WALK;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, pcol_reg, prow_reg, LEN_W'(path_cnt_reg),
                            ovf_reg, found_reg};

    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg[0] <= tail_reg[0] && head_reg[1] <= tail_reg[1])
        else $error("queue head passed tail");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(tail_reg[0]) + 32'(tail_reg[1]) <= CELLS)
        else $error("open list holds more entries than cells");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> 32'(path_cnt_reg) == PATH_DEPTH)
        else $error("overflow with path store not full");

    a_nofind_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !found_reg) |-> path_cnt_reg == '0)
        else $error("path stored without a found search");

endmodule
`default_nettype wire
